/* hdl/qrs_pkg.sv */
// ---------------------------------------------------------------------------
// qrs_pkg
// shared constants and types of the quadratic root solver
// ---------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ROOT_WIDTH     = 48;
  localparam int COUNT_WIDTH    = 2;

  localparam logic [COUNT_WIDTH-1:0] CNT_NONE = 2'd0;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = 2'd1;
  localparam logic [COUNT_WIDTH-1:0] CNT_TWO  = 2'd2;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ZERO,
    KIND_LIN,
    KIND_PURE,
    KIND_TWO,
    KIND_DOUBLE
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  neg_a;
  } ctl_t;

endpackage

`default_nettype wire

/* hdl/qrs_coef_if.sv */
// ---------------------------------------------------------------------------
// qrs_coef_if
// coefficient request channel
// ---------------------------------------------------------------------------
`default_nettype none

interface qrs_coef_if
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

`default_nettype wire

/* hdl/qrs_root_if.sv */
// ---------------------------------------------------------------------------
// qrs_root_if
// root result channel
// ---------------------------------------------------------------------------
`default_nettype none

interface qrs_root_if
  import qrs_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic [COUNT_WIDTH-1:0]       root_count;
  logic signed [ROOT_WIDTH-1:0] root_first;
  logic signed [ROOT_WIDTH-1:0] root_second;

  modport source (output valid, root_count, root_first, root_second, input ready);
  modport sink (input valid, root_count, root_first, root_second, output ready);
endinterface

`default_nettype wire

/* hdl/qrs_prep.sv */
// ---------------------------------------------------------------------------
// qrs_prep
// two stages: magnitudes and products, then discriminant and case decode
// ---------------------------------------------------------------------------
`default_nettype none

module qrs_prep
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic signed [COEF_WIDTH-1:0] a_i,
  input  wire logic signed [COEF_WIDTH-1:0] b_i,
  input  wire logic signed [COEF_WIDTH-1:0] c_i,
  output logic                              valid_o,
  output ctl_t                              ctl_o,
  output logic [2*COEF_WIDTH:0]             d_o,
  output logic [COEF_WIDTH-1:0]             mag_a_o,
  output logic [COEF_WIDTH-1:0]             mag_c_o,
  output logic signed [COEF_WIDTH-1:0]      b_o
);

  localparam int CW = COEF_WIDTH;

  logic [CW-1:0] ma, mb, mc;

  logic                 v1_q;
  logic [CW-1:0]        ma_q, mc_q;
  logic signed [CW-1:0] b1_q;
  logic [2*CW-1:0]      bb_q, ac_q;
  logic                 az_q, bz_q, cz_q, na_q, nc_q;

  logic [2*CW+1:0] bbx, ac4, dsum, ddif;
  logic            opp;
  kind_e           kind;

  logic                 v2_q;
  ctl_t                 ctl_q;
  logic [2*CW:0]        d_q;
  logic [CW-1:0]        ma2_q, mc2_q;
  logic signed [CW-1:0] b2_q;

  always_comb begin
    ma = a_i[CW-1] ? (~a_i + 1'b1) : a_i;
    mb = b_i[CW-1] ? (~b_i + 1'b1) : b_i;
    mc = c_i[CW-1] ? (~c_i + 1'b1) : c_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q <= ma;
      mc_q <= mc;
      b1_q <= b_i;
      bb_q <= (2*CW)'(mb) * (2*CW)'(mb);
      ac_q <= (2*CW)'(ma) * (2*CW)'(mc);
      az_q <= (a_i == '0);
      bz_q <= (b_i == '0);
      cz_q <= (c_i == '0);
      na_q <= a_i[CW-1];
      nc_q <= c_i[CW-1];
    end
  end

  always_comb begin
    bbx  = {2'b00, bb_q};
    ac4  = {ac_q, 2'b00};
    dsum = bbx + ac4;
    ddif = bbx - ac4;
    opp  = na_q ^ nc_q;
    if (az_q) begin
      kind = KIND_NONE;
    end else if (bz_q && cz_q) begin
      kind = KIND_ZERO;
    end else if (cz_q) begin
      kind = KIND_LIN;
    end else if (bz_q) begin
      kind = opp ? KIND_PURE : KIND_NONE;
    end else if (opp || (bbx > ac4)) begin
      kind = KIND_TWO;
    end else if (bbx == ac4) begin
      kind = KIND_DOUBLE;
    end else begin
      kind = KIND_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q.kind  <= kind;
      ctl_q.neg_a <= na_q;
      d_q         <= opp ? dsum[2*CW:0] : ddif[2*CW:0];
      ma2_q       <= ma_q;
      mc2_q       <= mc_q;
      b2_q        <= b1_q;
    end
  end

  assign valid_o = v2_q;
  assign ctl_o   = ctl_q;
  assign d_o     = d_q;
  assign mag_a_o = ma2_q;
  assign mag_c_o = mc2_q;
  assign b_o     = b2_q;

endmodule

`default_nettype wire

/* hdl/qrs_div_pipe.sv */
// ---------------------------------------------------------------------------
// qrs_div_pipe
// unsigned restoring divider, one quotient bit per register stage
// ---------------------------------------------------------------------------
`default_nettype none

module qrs_div_pipe #(
  parameter int NUM_WIDTH = 32,
  parameter int DEN_WIDTH = 16,
  parameter int SB_WIDTH  = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [NUM_WIDTH-1:0] num_i,
  input  wire logic [DEN_WIDTH-1:0] den_i,
  input  wire logic [SB_WIDTH-1:0]  sb_i,
  output logic                      valid_o,
  output logic [NUM_WIDTH-1:0]      quo_o,
  output logic [SB_WIDTH-1:0]       sb_o
);

  localparam int NW = NUM_WIDTH;
  localparam int DW = DEN_WIDTH;

  logic          vld_q [NW];
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [SB_WIDTH-1:0] sb_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0]       nq_in;
    logic [DW-1:0]       rem_in, den_in;
    logic [SB_WIDTH-1:0] sb_in;
    logic                v_in;
    logic [DW:0]         trial, diff;
    logic                ge;

    if (k == 0) begin : g_first
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign sb_in  = sb_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign sb_in  = sb_q[k-1];
      assign v_in   = vld_q[k-1];
    end

    assign trial = {rem_in, nq_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]  <= {nq_in[NW-2:0], ge};
        rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        den_q[k] <= den_in;
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = nq_q[NW-1];
  assign sb_o    = sb_q[NW-1];

endmodule

`default_nettype wire

/* hdl/qrs_sqrt_pipe.sv */
// ---------------------------------------------------------------------------
// qrs_sqrt_pipe
// floored integer square root, one root bit per register stage
// ---------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_pipe #(
  parameter int ROOT_BITS = 16,
  parameter int SB_WIDTH  = 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [2*ROOT_BITS-1:0] rad_i,
  input  wire logic [SB_WIDTH-1:0]    sb_i,
  output logic                        valid_o,
  output logic [ROOT_BITS-1:0]        root_o,
  output logic [SB_WIDTH-1:0]         sb_o
);

  localparam int SW = ROOT_BITS;

  logic            vld_q  [SW];
  logic [2*SW-1:0] rad_q  [SW];
  logic [SW+1:0]   rem_q  [SW];
  logic [SW-1:0]   root_q [SW];
  logic [SB_WIDTH-1:0] sb_q [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [2*SW-1:0]     rad_in;
    logic [SW+1:0]       rem_in;
    logic [SW-1:0]       root_in;
    logic [SB_WIDTH-1:0] sb_in;
    logic                v_in;
    logic [SW+1:0]       trem, trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sb_in   = sb_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sb_in   = sb_q[k-1];
      assign v_in    = vld_q[k-1];
    end

    assign trem  = {rem_in[SW-1:0], rad_in[2*SW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = trem >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[2*SW-3:0], 2'b00};
        rem_q[k]  <= ge ? (trem - trial) : trem;
        root_q[k] <= {root_in[SW-2:0], ge};
        sb_q[k]   <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[SW-1];
  assign root_o  = root_q[SW-1];
  assign sb_o    = sb_q[SW-1];

endmodule

`default_nettype wire

/* hdl/quadratic_root_solver_core.sv */
// ---------------------------------------------------------------------------
// quadratic_root_solver_core
// real roots of a*x^2+b*x+c in signed fixed point, fully pipelined
//
//   channel  | dir | payload
//   coef_i   | in  | coef_a, coef_b, coef_c (signed COEF_WIDTH)
//   root_o   | out | root_count (2), root_first, root_second (signed 48)
//
// one request per cycle while root_o does not stall; requests pass the prep
// stages, the prescale divider, the root extractor, the numerator register,
// the final dividers and the output register. reset clears only the stage
// valid bits. a stall on root_o freezes every stage; coef_i.ready follows it.
// ---------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver_core
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  qrs_coef_if.sink    coef_i,
  qrs_root_if.source  root_o
);

  localparam int CW  = COEF_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DW  = 2 * CW + 1;
  localparam int N1W = CW + 2 * F;
  localparam int SW  = CW + F + 1;
  localparam int NSW = SW + 1;
  localparam int EW  = ((SW > ROOT_WIDTH) ? SW : ROOT_WIDTH) + 1;
  localparam int CTW = $bits(ctl_t);
  localparam int SB1 = CTW + DW + 2 * CW;
  localparam int SBS = CTW + 2 * CW;
  localparam int SBA = CTW + SW + 1;

  logic en;

  // prep stages
  logic                 p_vld;
  ctl_t                 p_ctl;
  logic [DW-1:0]        p_d;
  logic [CW-1:0]        p_ma, p_mc;
  logic signed [CW-1:0] p_b;

  // prescale divider
  logic                 q_vld;
  logic [N1W-1:0]       q_quo;
  logic [SB1-1:0]       q_sb;
  ctl_t                 q_ctl;
  logic [DW-1:0]        q_d;
  logic [CW-1:0]        q_ma;
  logic signed [CW-1:0] q_b;
  logic [2*SW-1:0]      rad;

  // root extractor
  logic                 s_vld;
  logic [SW-1:0]        s_root;
  logic [SBS-1:0]       s_sb;
  ctl_t                 s_ctl;
  logic [CW-1:0]        s_ma;
  logic signed [CW-1:0] s_b;

  // numerator forming
  logic [NSW-1:0] nb, sx, n1, n2;
  logic           f_vld_q;
  ctl_t           f_ctl_q;
  logic [SW-1:0]  f_s_q, f_m1_q, f_m2_q;
  logic           f_ng1_q, f_ng2_q;
  logic [CW:0]    f_dm_q;

  // final dividers
  logic          a_vld, b_vld;
  logic [SW-1:0] a_quo, b_quo;
  logic [SBA-1:0] a_sb;
  logic          b_sb;
  ctl_t          a_ctl;
  logic [SW-1:0] a_s;
  logic          a_ng;

  // output register
  logic [COUNT_WIDTH-1:0] cnt_d;
  logic [ROOT_WIDTH-1:0]  r1_d, r2_d;
  logic                   o_vld_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic [ROOT_WIDTH-1:0]  r1_q, r2_q;

  function automatic logic [ROOT_WIDTH-1:0] sat_root(input logic neg, input logic [SW-1:0] m);
    logic [EW-1:0] mx;
    logic [EW-1:0] lim;
    logic [EW-1:0] nv;
    logic [ROOT_WIDTH-1:0] res;
    mx  = EW'(m);
    lim = EW'({(ROOT_WIDTH-1){1'b1}});
    nv  = -mx;
    if (!neg) begin
      res = (mx > lim) ? lim[ROOT_WIDTH-1:0] : mx[ROOT_WIDTH-1:0];
    end else if (mx > lim) begin
      res = {1'b1, {(ROOT_WIDTH-1){1'b0}}};
    end else begin
      res = nv[ROOT_WIDTH-1:0];
    end
    return res;
  endfunction

  assign en           = !o_vld_q || root_o.ready;
  assign coef_i.ready = en;

  qrs_prep #(
    .COEF_WIDTH(CW)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (coef_i.valid),
    .a_i     (coef_i.coef_a),
    .b_i     (coef_i.coef_b),
    .c_i     (coef_i.coef_c),
    .valid_o (p_vld),
    .ctl_o   (p_ctl),
    .d_o     (p_d),
    .mag_a_o (p_ma),
    .mag_c_o (p_mc),
    .b_o     (p_b)
  );

  qrs_div_pipe #(
    .NUM_WIDTH(N1W),
    .DEN_WIDTH(CW),
    .SB_WIDTH (SB1)
  ) u_div_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_vld),
    .num_i   ({p_mc, {(2*F){1'b0}}}),
    .den_i   (p_ma),
    .sb_i    ({p_ctl, p_d, p_ma, p_b}),
    .valid_o (q_vld),
    .quo_o   (q_quo),
    .sb_o    (q_sb)
  );

  assign {q_ctl, q_d, q_ma, q_b} = q_sb;
  assign rad = (q_ctl.kind == KIND_PURE) ? (2*SW)'(q_quo) : {1'b0, q_d, {(2*F){1'b0}}};

  qrs_sqrt_pipe #(
    .ROOT_BITS(SW),
    .SB_WIDTH (SBS)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (q_vld),
    .rad_i   (rad),
    .sb_i    ({q_ctl, q_ma, q_b}),
    .valid_o (s_vld),
    .root_o  (s_root),
    .sb_o    (s_sb)
  );

  assign {s_ctl, s_ma, s_b} = s_sb;

  always_comb begin
    nb = NSW'(-({{(NSW-CW){s_b[CW-1]}}, s_b} <<< F));
    sx = {1'b0, s_root};
    n1 = (s_ctl.kind == KIND_TWO) ? (nb + sx) : nb;
    n2 = (s_ctl.kind == KIND_TWO) ? (nb - sx) : nb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= s_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_ctl_q <= s_ctl;
      f_s_q   <= s_root;
      f_m1_q  <= n1[NSW-1] ? SW'(-n1) : n1[SW-1:0];
      f_m2_q  <= n2[NSW-1] ? SW'(-n2) : n2[SW-1:0];
      f_ng1_q <= n1[NSW-1] ^ s_ctl.neg_a;
      f_ng2_q <= n2[NSW-1] ^ s_ctl.neg_a;
      f_dm_q  <= (s_ctl.kind == KIND_LIN) ? {1'b0, s_ma} : {s_ma, 1'b0};
    end
  end

  qrs_div_pipe #(
    .NUM_WIDTH(SW),
    .DEN_WIDTH(CW + 1),
    .SB_WIDTH (SBA)
  ) u_div_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld_q),
    .num_i   (f_m1_q),
    .den_i   (f_dm_q),
    .sb_i    ({f_ctl_q, f_s_q, f_ng1_q}),
    .valid_o (a_vld),
    .quo_o   (a_quo),
    .sb_o    (a_sb)
  );

  qrs_div_pipe #(
    .NUM_WIDTH(SW),
    .DEN_WIDTH(CW + 1),
    .SB_WIDTH (1)
  ) u_div_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld_q),
    .num_i   (f_m2_q),
    .den_i   (f_dm_q),
    .sb_i    (f_ng2_q),
    .valid_o (b_vld),
    .quo_o   (b_quo),
    .sb_o    (b_sb)
  );

  assign {a_ctl, a_s, a_ng} = a_sb;

  always_comb begin
    cnt_d = CNT_NONE;
    r1_d  = '0;
    r2_d  = '0;
    unique case (a_ctl.kind)
      KIND_ZERO: begin
        cnt_d = CNT_ONE;
      end
      KIND_LIN: begin
        cnt_d = CNT_TWO;
        r2_d  = sat_root(a_ng, a_quo);
      end
      KIND_PURE: begin
        cnt_d = CNT_TWO;
        r1_d  = sat_root(1'b1, a_s);
        r2_d  = sat_root(1'b0, a_s);
      end
      KIND_TWO: begin
        cnt_d = CNT_TWO;
        r1_d  = sat_root(a_ng, a_quo);
        r2_d  = sat_root(b_sb, b_quo);
      end
      KIND_DOUBLE: begin
        cnt_d = CNT_ONE;
        r1_d  = sat_root(a_ng, a_quo);
        r2_d  = sat_root(a_ng, a_quo);
      end
      default: begin
        cnt_d = CNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en) begin
      o_vld_q <= a_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cnt_q <= cnt_d;
      r1_q  <= r1_d;
      r2_q  <= r2_d;
    end
  end

  assign root_o.valid       = o_vld_q;
  assign root_o.root_count  = cnt_q;
  assign root_o.root_first  = r1_q;
  assign root_o.root_second = r2_q;

  a_lanes_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld == b_vld)
    else $error("final divider lanes out of step");

  a_count_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q |-> (cnt_q == CNT_NONE || cnt_q == CNT_ONE || cnt_q == CNT_TWO))
    else $error("illegal root count");

  a_none_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && cnt_q == CNT_NONE) |-> (r1_q == '0 && r2_q == '0))
    else $error("roots not cleared without real roots");

  a_single_equal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && cnt_q == CNT_ONE) |-> (r1_q == r2_q))
    else $error("single root reported with two values");

endmodule

`default_nettype wire
